// File: rtl/mdet_pkg.sv
// Shared types and constants for the matrix determinant core.
// Used by mdet_ctrl, mdet_dp and matrix_determinant_core.
package mdet_pkg;

  localparam int MAX_ORDER = 5;
  localparam int MASK_W    = MAX_ORDER;
  localparam int NMASK     = 1 << MAX_ORDER;
  localparam int IDX_W     = 3;
  localparam int ELEM_W    = 12;
  localparam int ACC_W     = 64;
  localparam int DET_W     = 63;
  localparam logic [IDX_W-1:0] ORDER_RST = IDX_W'(4);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_SEL,
    ST_MLO,
    ST_MHI,
    ST_ACC,
    ST_STORE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              init;
    logic              load;
    logic              mul_lo;
    logic              mul_hi;
    logic              acc_add;
    logic              acc_neg;
    logic              store_f;
    logic              capture;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [MASK_W-1:0] mask;
  } cmd_t;

  function automatic logic [IDX_W-1:0] popcnt(input logic [MASK_W-1:0] m);
    logic [IDX_W-1:0] c;
    c = '0;
    for (int i = 0; i < MASK_W; i++) begin
      c = c + IDX_W'(m[i]);
    end
    return c;
  endfunction

endpackage

// File: rtl/mdet_ctrl.sv
// Sequencer for the subset-minor expansion: walks row subsets and rows.
// Depends on mdet_pkg; drives mdet_dp through cmd_t.
module mdet_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mdet_pkg::IDX_W-1:0] cfg_wdata,
  input  logic                      in_valid,
  input  logic                      is_last,
  input  logic                      out_stall,
  output logic                      in_stall,
  output logic                      out_valid,
  output mdet_pkg::cmd_t            cmd
);
  import mdet_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  order;
  logic [IDX_W-1:0]  n_eff;
  logic [MASK_W-1:0] mask;
  logic [IDX_W-1:0]  r;
  logic [MASK_W-1:0] full;
  logic              r_last;
  logic              r_in;
  logic [MASK_W-1:0] below;
  logic [IDX_W-1:0]  k;
  logic [IDX_W-1:0]  pos;

  always_comb begin
    if (order == '0) begin
      n_eff = IDX_W'(1);
    end else if (order > IDX_W'(MAX_ORDER)) begin
      n_eff = IDX_W'(MAX_ORDER);
    end else begin
      n_eff = order;
    end
  end

  assign full   = MASK_W'((NMASK - 1) >> (MAX_ORDER - int'(n_eff)));
  assign r_last = (r == n_eff - IDX_W'(1));
  assign r_in   = mask[r];
  assign below  = MASK_W'((1 << r) - 1);
  assign k      = popcnt(mask);
  assign pos    = popcnt(mask & below);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      order <= ORDER_RST;
      mask  <= '0;
      r     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        order <= cfg_wdata;
      end
      case (state)
        ST_INIT: begin
          mask <= MASK_W'(1);
          r    <= '0;
        end
        ST_SEL: begin
          if (!r_in && !r_last) begin
            r <= r + IDX_W'(1);
          end
        end
        ST_ACC: begin
          if (!r_last) begin
            r <= r + IDX_W'(1);
          end
        end
        ST_STORE: begin
          mask <= mask + MASK_W'(1);
          r    <= '0;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid && is_last) state_next = ST_INIT;
      ST_INIT:  state_next = ST_SEL;
      ST_SEL: begin
        if (r_in) begin
          state_next = ST_MLO;
        end else if (r_last) begin
          state_next = ST_STORE;
        end
      end
      ST_MLO:   state_next = ST_MHI;
      ST_MHI:   state_next = ST_ACC;
      ST_ACC:   state_next = r_last ? ST_STORE : ST_SEL;
      ST_STORE: state_next = (mask == full) ? ST_OUT : ST_SEL;
      ST_OUT:   if (!out_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.row     = r;
    cmd.col     = k - IDX_W'(1);
    cmd.mask    = mask;
    cmd.acc_neg = pos[0] ^ k[0] ^ 1'b1;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_INIT:  cmd.init = 1'b1;
      ST_SEL:   cmd.load = r_in;
      ST_MLO:   cmd.mul_lo = 1'b1;
      ST_MHI:   cmd.mul_hi = 1'b1;
      ST_ACC:   cmd.acc_add = 1'b1;
      ST_STORE: begin
        cmd.store_f = 1'b1;
        cmd.capture = (mask == full);
      end
      ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/mdet_dp.sv
// Datapath: element store, minor table, split 12x64 multiply, accumulator.
// Depends on mdet_pkg; commanded by mdet_ctrl.
module mdet_dp (
  input  logic                               clk,
  input  logic                               wr_en,
  input  logic signed [mdet_pkg::ELEM_W-1:0] elem_value,
  input  logic [mdet_pkg::IDX_W-1:0]         row_index,
  input  logic [mdet_pkg::IDX_W-1:0]         col_index,
  input  mdet_pkg::cmd_t                     cmd,
  output logic signed [mdet_pkg::DET_W-1:0]  det_value
);
  import mdet_pkg::*;

  logic signed [ELEM_W-1:0] mat [MAX_ORDER][MAX_ORDER];
  logic [ACC_W-1:0]         fval [NMASK];
  logic signed [ELEM_W-1:0] a_op;
  logic [ACC_W-1:0]         f_op;
  logic [ACC_W-1:0]         p_lo;
  logic [31:0]              p_hi;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         term;
  logic signed [ELEM_W+32:0] lo_full;
  logic signed [ELEM_W+31:0] hi_full;
  logic [MASK_W-1:0]        sub_mask;

  assign sub_mask = cmd.mask & ~MASK_W'(1 << cmd.row);
  assign lo_full  = a_op * $signed({1'b0, f_op[31:0]});
  assign hi_full  = a_op * $signed(f_op[63:32]);
  assign term     = p_lo + {p_hi, 32'b0};

  always_ff @(posedge clk) begin
    if (wr_en && row_index < IDX_W'(MAX_ORDER) && col_index < IDX_W'(MAX_ORDER)) begin
      mat[row_index][col_index] <= elem_value;
    end
    if (cmd.load) begin
      a_op <= mat[cmd.row][cmd.col];
      f_op <= fval[sub_mask];
    end
    if (cmd.mul_lo) begin
      p_lo <= ACC_W'(lo_full);
    end
    if (cmd.mul_hi) begin
      p_hi <= hi_full[31:0];
    end
    if (cmd.init) begin
      fval[0] <= ACC_W'(1);
      acc     <= '0;
    end else if (cmd.acc_add) begin
      acc <= cmd.acc_neg ? acc - term : acc + term;
    end else if (cmd.store_f) begin
      fval[cmd.mask] <= acc;
      acc            <= '0;
    end
    if (cmd.capture) begin
      det_value <= acc[DET_W-1:0];
    end
  end

endmodule

// File: rtl/matrix_determinant_core.sv
// Top level of the matrix determinant core: controller plus datapath.
// Depends on mdet_pkg, mdet_ctrl and mdet_dp.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  config   | cfg_we              | cfg_wdata (matrix_order)
//  input    | in_valid / in_stall | elem_value, row_index, col_index, is_last
//  output   | out_valid/out_stall | det_value
//
// One element per cycle while idle. After the last element the minor
// table is built over all row subsets after a start step: per subset one
// select step for each row of the order, three more steps (multiply low,
// multiply high, accumulate) for each row in the subset and one for
// write-back, before the result is offered. Each term is built from two
// partial products of the table entry, its low half and its high half.
// Input is stalled from the last element until the result transaction completes. Reset: rst, synchronous.
module matrix_determinant_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [mdet_pkg::IDX_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [mdet_pkg::ELEM_W-1:0] elem_value,
  input  logic [mdet_pkg::IDX_W-1:0]         row_index,
  input  logic [mdet_pkg::IDX_W-1:0]         col_index,
  input  logic                               is_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mdet_pkg::DET_W-1:0]  det_value
);
  import mdet_pkg::*;

  cmd_t cmd;
  logic wr_en;

  assign wr_en = in_valid && !in_stall;

  mdet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .is_last   (is_last),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  mdet_dp u_dp (
    .clk        (clk),
    .wr_en      (wr_en),
    .elem_value (elem_value),
    .row_index  (row_index),
    .col_index  (col_index),
    .cmd        (cmd),
    .det_value  (det_value)
  );

  a_out_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("result while accepting input");

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && is_last) |=> in_stall)
    else $error("input not stalled after last element");

  a_no_cmd_idle: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !(cmd.load || cmd.acc_add || cmd.store_f))
    else $error("datapath command while idle");

endmodule

// File: sim/tb_matrix_determinant_core.sv
`timescale 1ns / 1ps
// Testbench for matrix_determinant_core: loads square matrices of every order,
// predicts each determinant by cofactor expansion and checks it. Needs mdet_pkg.
module tb_matrix_determinant_core;
  import mdet_pkg::*;

  typedef struct {
    logic signed [ELEM_W-1:0] val;
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic                     last;
    logic                     chk;
    logic signed [DET_W-1:0]  det;
  } elem_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ELEM_W-1:0] elem_value = '0;
  logic [IDX_W-1:0] row_index = '0;
  logic [IDX_W-1:0] col_index = '0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DET_W-1:0] det_value;

  logic signed [ELEM_W-1:0] mat_shadow [MAX_ORDER][MAX_ORDER];
  logic [IDX_W-1:0] order_shadow;
  logic signed [DET_W-1:0] det_queue [$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_off = 0;
  elem_row_t dir_tab [$];

  matrix_determinant_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .elem_value(elem_value),
    .row_index(row_index), .col_index(col_index), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall), .det_value(det_value)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [63:0] minor_det(int c, logic [MASK_W-1:0] m, int n);
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] t;
    int p;
    sum = '0;
    p = 0;
    for (int r = 0; r < n; r++) begin
      if (m[r]) begin
        e = 64'(signed'(mat_shadow[r][c]));
        if (c == n - 1) return e;
        t = e * minor_det(c + 1, m & ~(MASK_W'(1) << r), n);
        if (p[0]) sum = sum - t;
        else sum = sum + t;
        p++;
      end
    end
    return sum;
  endfunction

  function automatic int eff_order();
    int n;
    n = int'(order_shadow);
    if (n < 1) n = 1;
    if (n > MAX_ORDER) n = MAX_ORDER;
    return n;
  endfunction

  task automatic predict_det(input elem_row_t it);
    int n;
    if (it.row < MAX_ORDER && it.col < MAX_ORDER) mat_shadow[it.row][it.col] = it.val;
    if (it.last) begin
      n = eff_order();
      det_queue.push_back(DET_W'(minor_det(0, MASK_W'((1 << n) - 1), n)));
    end
  endtask

  function automatic int gap_len();
    int g;
    g = $urandom_range(0, 99);
    if (g < 55) g = 0;
    else if (g < 95) g = $urandom_range(1, 3);
    else g = $urandom_range(10, 40);
    return g;
  endfunction

  // valid stays high when no gap follows; the next call reloads the payload
  task automatic send_elem(input elem_row_t it);
    int g;
    in_valid   <= 1'b1;
    elem_value <= it.val;
    row_index  <= it.row;
    col_index  <= it.col;
    is_last    <= it.last;
    do @(posedge clk); while (in_stall);
    predict_det(it);
    if (it.chk && it.last && det_queue.size() > 0 && det_queue[$] !== it.det) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row: expected %0d, predicted %0d", it.det, det_queue[$]);
    end
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic set_order(input logic [IDX_W-1:0] n);
    in_valid <= 1'b0;
    while (det_queue.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    order_shadow = n;
  endtask

  // full matrix of current order, every element written, last marked
  task automatic send_matrix(input int mode);
    int n;
    int lr;
    int lc;
    elem_row_t it;
    n = eff_order();
    lr = $urandom_range(0, n - 1);
    lc = $urandom_range(0, n - 1);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (r == lr && c == lc) continue;
        it.row = IDX_W'(r); it.col = IDX_W'(c); it.last = 0; it.chk = 0; it.det = '0;
        case (mode)
          0: it.val = ELEM_W'($urandom);
          1: it.val = $urandom_range(0, 1) ? 12'sh7ff : 12'sh800;
          default: it.val = ELEM_W'($urandom_range(0, 6) - 3);
        endcase
        send_elem(it);
        if ($urandom_range(0, 9) == 0) begin
          it.row = IDX_W'($urandom_range(5, 7));
          it.col = IDX_W'($urandom);
          it.val = ELEM_W'($urandom);
          send_elem(it);
        end
      end
    it.row = IDX_W'(lr); it.col = IDX_W'(lc); it.last = 1; it.chk = 0;
    it.val = ELEM_W'($urandom);
    send_elem(it);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (det_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", det_value);
      end else begin
        if (det_value !== det_queue[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("det mismatch: expected %0d, got %0d", det_queue[0], det_value);
        end
        void'(det_queue.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(0, 99) < 25);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || rst)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic elem_row_t mk(int v, int r, int c, bit l, bit k, longint d);
    elem_row_t it;
    it.val = ELEM_W'(v); it.row = IDX_W'(r); it.col = IDX_W'(c);
    it.last = l; it.chk = k; it.det = DET_W'(d);
    return it;
  endfunction

  initial begin
    int cnt;
    elem_row_t it;
    order_shadow = ORDER_RST;
    for (int r = 0; r < MAX_ORDER; r++)
      for (int c = 0; c < MAX_ORDER; c++) mat_shadow[r][c] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // order 1 extremes, out-of-range index, order zero, order 2 extremes, order above max and order 5
    set_order(3'd1);
    dir_tab.push_back(mk(2047, 0, 0, 1, 1, 2047));
    dir_tab.push_back(mk(-2048, 0, 0, 1, 1, -2048));
    dir_tab.push_back(mk(5, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(-7, 7, 4, 1, 1, 5));
    dir_tab.push_back(mk(-7, 2, 7, 1, 1, 5));
    dir_tab.push_back(mk(-1, 0, 0, 1, 1, -1));
    foreach (dir_tab[i]) send_elem(dir_tab[i]);
    dir_tab.delete();
    set_order(3'd0);
    send_elem(mk(1234, 0, 0, 1, 1, 1234));
    set_order(3'd2);
    dir_tab.push_back(mk(-2048, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(2047, 0, 1, 0, 0, 0));
    dir_tab.push_back(mk(2047, 1, 0, 0, 0, 0));
    dir_tab.push_back(mk(-2048, 1, 1, 1, 1, 4194304 - 4190209));
    dir_tab.push_back(mk(3, 1, 1, 1, 1, -6144 - 4190209));
    foreach (dir_tab[i]) send_elem(dir_tab[i]);
    dir_tab.delete();
    set_order(3'd7);
    send_matrix(1);
    set_order(3'd5);
    send_matrix(1);
    send_matrix(2);

    // long receiver hold-off while the sender keeps offering
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      begin
        send_matrix(0);
        send_matrix(0);
      end
    join

    cnt = 0;
    while (cnt < 1650) begin
      set_order(IDX_W'($urandom_range(0, 99) < 15 ? $urandom_range(0, 7) :
                                                   $urandom_range(1, 3)));
      repeat ($urandom_range(2, 8)) begin
        send_matrix($urandom_range(0, 9) == 0 ? 1 : ($urandom_range(0, 4) == 0 ? 2 : 0));
        cnt += eff_order() * eff_order();
        if ($urandom_range(0, 19) == 0) begin
          it = mk($urandom, $urandom, $urandom, 0, 0, 0);
          if (it.row < MAX_ORDER && it.col < MAX_ORDER) it.row = IDX_W'(6);
          send_elem(it);
        end
      end
    end

    in_valid <= 1'b0;
    while (det_queue.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// File: sim.f
rtl/mdet_pkg.sv
rtl/mdet_ctrl.sv
rtl/mdet_dp.sv
rtl/matrix_determinant_core.sv
sim/tb_matrix_determinant_core.sv
